// ----- design/plde_pkg.sv -----
// Shared constants and types for the packet loss and delay emulator.
package plde_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int HANDLE_BITS_DEF = 8;

  localparam int TIME_W  = 32;
  localparam int LEN_W   = 16;
  localparam int DELAY_W = 16;
  localparam int THR_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [2:0] {
    OC_FORWARDED = 3'd0,
    OC_QUEUED    = 3'd1,
    OC_LOST      = 3'd2,
    OC_OVERSIZE  = 3'd3,
    OC_FULL      = 3'd4,
    OC_RELEASED  = 3'd5,
    OC_TICK_DONE = 3'd6
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOSS_THRESHOLD = 2'd0,
    REG_MTU            = 2'd1,
    REG_MIN_DELAY      = 2'd2,
    REG_DELAY_VARIANCE = 2'd3
  } cfg_reg_t;

  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_TICK = 1'b1;

endpackage

// ----- design/plde_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/plde_mod.sv -----
// Bit-serial restoring remainder unit: 32-bit dividend modulo 16-bit divisor.
module plde_mod (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [plde_pkg::TIME_W-1:0]    dividend,
  input  logic [plde_pkg::DELAY_W-1:0]   divisor,
  output logic                           done,
  output logic [plde_pkg::DELAY_W-1:0]   remainder
);
  import plde_pkg::*;

  logic                 busy;
  logic [4:0]           step;
  logic [TIME_W-1:0]    dvd;
  logic [DELAY_W-1:0]   dvs;
  logic [DELAY_W:0]     rem;
  logic [DELAY_W:0]     trial;

  // One dividend bit is shifted in per cycle.
  assign trial = {rem[DELAY_W-1:0], dvd[TIME_W-1]};
  assign remainder = rem[DELAY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
        end else begin
          rem <= trial;
        end
        dvd  <= {dvd[TIME_W-2:0], 1'b0};
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/packet_loss_delay_emulator_top.sv -----
// Packet loss and delay emulator: top level with sequencer and held-descriptor store.
// Each beat on the input is a send request or a time tick, and the block stalls its input
// until that beat's results are all handed on. A lost or oversize send goes straight to its
// result; a send that passes those checks has its delay formed (a nonzero variance first waits
// for the bit-serial remainder unit) and is then forwarded, refused as full or put into an
// empty store. A send that is queued into a non-empty store also walks the ring-ordered store
// through its single RAM read port, reading and comparing entries in turn and then reading and
// writing each entry that moves up. A tick reads and compares the head entry, releasing each
// due entry, then gives its final beat. Output stalls lengthen every path.
module packet_loss_delay_emulator_top #(
  parameter int QUEUE_DEPTH = plde_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = plde_pkg::HANDLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic [plde_pkg::TIME_W-1:0]        now,
  input  logic [plde_pkg::LEN_W-1:0]         packet_length,
  input  logic [HANDLE_BITS-1:0]             packet_handle,
  input  logic [plde_pkg::DELAY_W-1:0]       loss_random,
  input  logic [plde_pkg::TIME_W-1:0]        delay_random,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         outcome,
  output logic [HANDLE_BITS-1:0]             out_handle,
  output logic [plde_pkg::LEN_W-1:0]         out_length,
  output logic                               last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [plde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plde_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import plde_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = TIME_W + HANDLE_BITS + LEN_W;

  typedef enum logic [3:0] {
    IDLE, DIV, DELAY, SCAN_RD, SCAN_CMP, SHIFT_RD, SHIFT_WR, PUT, EMIT, TICK_RD, TICK_CMP
  } state_t;

  state_t state;

  logic [THR_W-1:0]      loss_threshold;
  logic [LEN_W-1:0]      mtu;
  logic [DELAY_W-1:0]    min_extra_delay;
  logic [DELAY_W-1:0]    delay_variance;

  logic [TIME_W-1:0]      now_q;
  logic [TIME_W-1:0]      due_q;
  logic [LEN_W-1:0]       len_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  outcome_t               pend_oc;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;

  logic          accept;
  logic          lost;
  logic          oversize;
  logic          slot_free;
  logic          load_beat;
  logic          div_start;
  logic          div_done;
  logic [DELAY_W-1:0] div_rem;
  logic [DELAY_W-1:0] delay;
  logic [TIME_W-1:0]  cmp_diff;
  logic [TIME_W-1:0]  age;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;
  logic [TIME_W-1:0] rd_due;

  // Logical position in the ring to physical RAM address.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] x);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, hd} + {1'b0, x};
    if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
      s = s - (CW + 1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign load_beat = slot_free && ((state == EMIT) || (state == TICK_CMP && !age[TIME_W-1]));

  assign lost      = (loss_threshold != '0) && ({1'b0, loss_random} < loss_threshold);
  assign oversize  = packet_length > mtu;
  assign div_start = accept && (action == ACT_SEND) && !lost && !oversize &&
                     (delay_variance != '0);

  assign delay    = min_extra_delay + ((delay_variance != '0) ? div_rem : '0);
  assign rd_due   = ram_rdata[DW-1 -: TIME_W];
  assign cmp_diff = rd_due - due_q;
  assign age      = now_q - rd_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_threshold  <= '0;
      mtu             <= '1;
      min_extra_delay <= '0;
      delay_variance  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOSS_THRESHOLD: loss_threshold  <= cfg_data;
        REG_MTU:            mtu             <= cfg_data[LEN_W-1:0];
        REG_MIN_DELAY:      min_extra_delay <= cfg_data[DELAY_W-1:0];
        REG_DELAY_VARIANCE: delay_variance  <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  plde_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (delay_random),
    .divisor   (delay_variance),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(head, pos);
    ram_wdata = {due_q, hnd_q, len_q};
    ram_raddr = phys(head, idx);
    unique case (state)
      SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head, idx + CW'(1));
        ram_wdata = ram_rdata;
      end
      PUT: begin
        ram_we = 1'b1;
      end
      // The head entry stays on the read port while its release waits for the output.
      TICK_RD, TICK_CMP: begin
        ram_raddr = head;
      end
      default: ;
    endcase
  end

  plde_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      count     <= '0;
    end else begin
      if (out_valid && !out_stall && !load_beat) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            now_q <= now;
            len_q <= packet_length;
            hnd_q <= packet_handle;
            if (action == ACT_TICK) begin
              pend_oc <= OC_TICK_DONE;
              state   <= (count == '0) ? EMIT : TICK_RD;
            end else if (lost) begin
              pend_oc <= OC_LOST;
              state   <= EMIT;
            end else if (oversize) begin
              pend_oc <= OC_OVERSIZE;
              state   <= EMIT;
            end else if (delay_variance != '0) begin
              state <= DIV;
            end else begin
              state <= DELAY;
            end
          end
        end
        DIV: begin
          if (div_done) begin
            state <= DELAY;
          end
        end
        DELAY: begin
          idx   <= '0;
          due_q <= now_q + {{(TIME_W - DELAY_W){1'b0}}, delay};
          if (delay == '0) begin
            pend_oc <= OC_FORWARDED;
            state   <= EMIT;
          end else if (count == CW'(QUEUE_DEPTH)) begin
            pend_oc <= OC_FULL;
            state   <= EMIT;
          end else if (count == '0) begin
            pos   <= '0;
            state <= PUT;
          end else begin
            state <= SCAN_RD;
          end
        end
        SCAN_RD: begin
          state <= SCAN_CMP;
        end
        SCAN_CMP: begin
          // The new entry goes before the first one due strictly later.
          if (cmp_diff != '0 && !cmp_diff[TIME_W-1]) begin
            pos   <= idx;
            idx   <= count - CW'(1);
            state <= SHIFT_RD;
          end else if (idx + CW'(1) == count) begin
            pos   <= count;
            state <= PUT;
          end else begin
            idx   <= idx + CW'(1);
            state <= SCAN_RD;
          end
        end
        SHIFT_RD: begin
          state <= SHIFT_WR;
        end
        SHIFT_WR: begin
          if (idx == pos) begin
            state <= PUT;
          end else begin
            idx   <= idx - CW'(1);
            state <= SHIFT_RD;
          end
        end
        PUT: begin
          count   <= count + CW'(1);
          pend_oc <= OC_QUEUED;
          state   <= EMIT;
        end
        EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            outcome   <= pend_oc;
            last      <= 1'b1;
            if (pend_oc == OC_TICK_DONE) begin
              out_handle <= '0;
              out_length <= '0;
            end else begin
              out_handle <= hnd_q;
              out_length <= len_q;
            end
            state <= IDLE;
          end
        end
        TICK_RD: begin
          state <= TICK_CMP;
        end
        TICK_CMP: begin
          if (age[TIME_W-1]) begin
            state <= EMIT;
          end else if (slot_free) begin
            out_valid  <= 1'b1;
            outcome    <= OC_RELEASED;
            last       <= 1'b0;
            out_handle <= ram_rdata[LEN_W +: HANDLE_BITS];
            out_length <= ram_rdata[LEN_W-1:0];
            head       <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
            count      <= count - CW'(1);
            state      <= (count == CW'(1)) ? EMIT : TICK_RD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- design/plde_checker.sv -----
// Port-level checker for the packet loss and delay emulator, bound to its top level.
module plde_checker #(
  parameter int HANDLE_BITS = plde_pkg::HANDLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [2:0]                    outcome,
  input logic [HANDLE_BITS-1:0]        out_handle,
  input logic [plde_pkg::LEN_W-1:0]    out_length,
  input logic                          last
);
  import plde_pkg::*;

  // A beat held back on the output keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(out_handle))
    else $error("stalled output beat changed");

  // Once a beat is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // Released entries never close an item.
  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OC_RELEASED |-> !last)
    else $error("released entry marked last");

  // A tick ends with an empty, final beat; every send result is final.
  a_final_beats: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OC_TICK_DONE || outcome == OC_FORWARDED ||
    outcome == OC_QUEUED || outcome == OC_LOST || outcome == OC_OVERSIZE ||
    outcome == OC_FULL) |-> last && (outcome != OC_TICK_DONE || out_length == '0))
    else $error("final beat malformed");

endmodule

bind packet_loss_delay_emulator_top plde_checker #(
  .HANDLE_BITS (HANDLE_BITS)
) u_plde_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .outcome    (outcome),
  .out_handle (out_handle),
  .out_length (out_length),
  .last       (last)
);
